// File: rtl/core/vrs_pkg.sv
// Shared types and constants for the variable-length record stack.
// Used by vrs_ram, vrs_ctrl and variable_record_stack_core; no dependencies.
package vrs_pkg;

   // Store geometry and record limits
   localparam int STACK_BYTES = 1024;
   localparam int HDR_BYTES   = 8;
   localparam int MAX_RECORD  = 64;

   localparam int ADDR_W = $clog2(STACK_BYTES);
   localparam int TOP_W  = $clog2(STACK_BYTES + 1);
   localparam int LEN_W  = 7;
   localparam int DATA_W = 8;

   // Input item kinds
   typedef enum logic [1:0] {
      KIND_PUSH  = 2'd0,
      KIND_POP   = 2'd1,
      KIND_PEEK  = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   // Result status codes
   typedef enum logic [2:0] {
      ST_DATA     = 3'd0,
      ST_NO_COPY  = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_REJECTED = 3'd3,
      ST_ACCEPTED = 3'd4
   } status_type;

   // Controller states
   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_PUSH1 = 6'b000010,
      S_FILL  = 6'b000100,
      S_OP    = 6'b001000,
      S_RDLEN = 6'b010000,
      S_READ  = 6'b100000
   } state_type;

   // Memory access from controller to store
   typedef struct packed {
      logic              we;
      logic [TOP_W-1:0]  waddr;
      logic [DATA_W-1:0] wdata;
      logic              re;
      logic [TOP_W-1:0]  raddr;
   } mem_req_type;

   // One result item
   typedef struct packed {
      logic              valid;
      status_type        status;
      logic [DATA_W-1:0] data;
      logic              last;
      logic              empty;
   } rsp_type;

endpackage

// File: rtl/core/vrs_ram.sv
// Byte store of the record stack: one write port, one registered read port.
// Depends on vrs_pkg for geometry and the access struct.
module vrs_ram (
   input  logic                       clock,
   input  vrs_pkg::mem_req_type       mem_req,
   output logic [vrs_pkg::DATA_W-1:0] rdata
);

   logic [vrs_pkg::DATA_W-1:0] mem [vrs_pkg::STACK_BYTES];
   logic [vrs_pkg::DATA_W-1:0] rdata_ff;

   // Write one byte
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr[vrs_pkg::ADDR_W-1:0]] <= mem_req.wdata;
      end
   end

   // Read one byte, data next cycle
   always_ff @(posedge clock) begin
      if (mem_req.re) begin
         rdata_ff <= mem[mem_req.raddr[vrs_pkg::ADDR_W-1:0]];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/vrs_ctrl.sv
// Sequencer of the record stack: push, zero fill, pop/peek read-out, clear.
// Depends on vrs_pkg; drives the byte store in vrs_ram.
module vrs_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_kind,
   input  logic [vrs_pkg::DATA_W-1:0] req_data_byte,
   input  logic [vrs_pkg::LEN_W-1:0]  req_length,
   input  logic                       req_last_byte,
   output vrs_pkg::mem_req_type       mem_req,
   input  logic [vrs_pkg::DATA_W-1:0] mem_rdata,
   output vrs_pkg::rsp_type           rsp_next
);

   localparam int TW = vrs_pkg::TOP_W;
   localparam int LW = vrs_pkg::LEN_W;
   localparam int DW = vrs_pkg::DATA_W;
   localparam logic [TW-1:0] TOP_EMPTY = TW'(vrs_pkg::STACK_BYTES);
   localparam logic [TW-1:0] HDR_T     = TW'(vrs_pkg::HDR_BYTES);
   localparam logic [LW-1:0] MAX_L     = LW'(vrs_pkg::MAX_RECORD);
   localparam logic [LW-1:0] BI_SAT    = {LW{1'b1}};

   vrs_pkg::state_type state_ff, state_in;
   logic [TW-1:0] top_ff, top_in;
   logic [LW-1:0] bi_ff, bi_in;
   logic          in_rec_ff, in_rec_in;
   logic          rej_ff, rej_in;
   logic [LW-1:0] rec_len_ff, rec_len_in;
   logic          ended_ff, ended_in;
   logic          op_pend_ff, op_pend_in;
   vrs_pkg::kind_type op_kind_ff, op_kind_in;
   logic [LW-1:0] op_len_ff, op_len_in;
   logic [DW-1:0] first_ff, first_in;
   logic [TW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LW-1:0] cnt_ff, cnt_in;

   vrs_pkg::kind_type kind;
   vrs_pkg::kind_type exec_kind;
   logic [LW-1:0]     exec_len;
   logic              accept;
   logic              need_fill;
   logic              op_go;
   logic [TW-1:0]     new_top;
   logic [TW:0]       pop_top;
   logic [DW-1:0]     hdr_byte;
   logic [LW-1:0]     stored;
   logic [LW-1:0]     n_copy;
   logic [LW-1:0]     bi_next;
   logic [LW-1:0]     bi_inc;

   assign kind      = vrs_pkg::kind_type'(req_kind);
   assign busy      = (state_ff != vrs_pkg::S_IDLE);
   assign accept    = start && (state_ff == vrs_pkg::S_IDLE);
   assign need_fill = in_rec_ff && !rej_ff && (bi_ff < rec_len_ff);
   assign op_go     = (accept && (kind != vrs_pkg::KIND_PUSH) && !need_fill) ||
                      (state_ff == vrs_pkg::S_OP);
   assign exec_kind = (state_ff == vrs_pkg::S_OP) ? op_kind_ff : kind;
   assign exec_len  = (state_ff == vrs_pkg::S_OP) ? op_len_ff : req_length;
   assign new_top   = top_ff - HDR_T - TW'(req_length);
   assign bi_inc    = bi_ff + LW'(1);

   // Clamp the stored header to the record limit
   assign hdr_byte = (mem_rdata > DW'(vrs_pkg::MAX_RECORD)) ?
                     DW'(vrs_pkg::MAX_RECORD) : mem_rdata;
   assign stored   = hdr_byte[LW-1:0];
   assign n_copy   = (stored < op_len_ff) ? stored : op_len_ff;
   assign pop_top  = (TW+1)'(top_ff) + (TW+1)'(HDR_T) + (TW+1)'(stored);

   // Next state, store accesses and result
   always_comb begin
      state_in   = state_ff;
      top_in     = top_ff;
      bi_in      = bi_ff;
      in_rec_in  = in_rec_ff;
      rej_in     = rej_ff;
      rec_len_in = rec_len_ff;
      ended_in   = ended_ff;
      op_pend_in = op_pend_ff;
      op_kind_in = op_kind_ff;
      op_len_in  = op_len_ff;
      first_in   = first_ff;
      rd_ptr_in  = rd_ptr_ff;
      cnt_in     = cnt_ff;
      bi_next    = bi_ff;
      mem_req    = '0;
      rsp_next   = '0;

      // Push byte
      if (accept && (kind == vrs_pkg::KIND_PUSH)) begin
         rsp_next.valid = 1'b1;
         rsp_next.last  = 1'b1;
         if (!in_rec_ff) begin
            if ((req_length > MAX_L) || (top_ff < HDR_T + TW'(req_length))) begin
               // Reject the whole record
               rsp_next.status = vrs_pkg::ST_REJECTED;
               rsp_next.empty  = (top_ff >= TOP_EMPTY);
               if (req_last_byte || (LW'(1) >= req_length)) begin
                  in_rec_in = 1'b0;
                  rej_in    = 1'b0;
                  bi_in     = '0;
               end else begin
                  in_rec_in = 1'b1;
                  rej_in    = 1'b1;
                  bi_in     = LW'(1);
               end
            end else begin
               // Allocate and write the header; first data byte follows
               top_in          = new_top;
               rec_len_in      = req_length;
               mem_req.we      = 1'b1;
               mem_req.waddr   = new_top;
               mem_req.wdata   = DW'(req_length);
               rsp_next.status = vrs_pkg::ST_ACCEPTED;
               rsp_next.empty  = (new_top >= TOP_EMPTY);
               rej_in          = 1'b0;
               if (req_length == '0) begin
                  in_rec_in = 1'b0;
                  bi_in     = '0;
               end else begin
                  in_rec_in = 1'b1;
                  bi_in     = LW'(1);
                  first_in  = req_data_byte;
                  ended_in  = req_last_byte || (req_length == LW'(1));
                  state_in  = vrs_pkg::S_PUSH1;
               end
            end
         end else if (rej_ff) begin
            // Drop bytes of a rejected record
            rsp_next.status = vrs_pkg::ST_REJECTED;
            rsp_next.empty  = (top_ff >= TOP_EMPTY);
            bi_next = (bi_ff == BI_SAT) ? bi_ff : bi_inc;
            if (req_last_byte || (bi_next >= req_length)) begin
               in_rec_in = 1'b0;
               rej_in    = 1'b0;
               bi_in     = '0;
            end else begin
               bi_in = bi_next;
            end
         end else begin
            // Store the next data byte
            rsp_next.status = vrs_pkg::ST_ACCEPTED;
            rsp_next.empty  = (top_ff >= TOP_EMPTY);
            if (bi_ff < rec_len_ff) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = top_ff + HDR_T + TW'(bi_ff);
               mem_req.wdata = req_data_byte;
               bi_next       = bi_inc;
            end
            if (req_last_byte || (bi_next >= rec_len_ff)) begin
               if (bi_next < rec_len_ff) begin
                  bi_in      = bi_next;
                  op_pend_in = 1'b0;
                  state_in   = vrs_pkg::S_FILL;
               end else begin
                  in_rec_in = 1'b0;
                  bi_in     = '0;
               end
            end else begin
               bi_in = bi_next;
            end
         end
      end

      // Pop, peek or clear behind an unfinished record: fill it first
      if (accept && (kind != vrs_pkg::KIND_PUSH) && need_fill) begin
         op_kind_in = kind;
         op_len_in  = req_length;
         op_pend_in = 1'b1;
         state_in   = vrs_pkg::S_FILL;
      end

      // Execute pop, peek or clear
      if (op_go) begin
         in_rec_in  = 1'b0;
         rej_in     = 1'b0;
         bi_in      = '0;
         op_pend_in = 1'b0;
         op_kind_in = exec_kind;
         op_len_in  = exec_len;
         state_in   = vrs_pkg::S_IDLE;
         if (exec_kind == vrs_pkg::KIND_CLEAR) begin
            top_in = TOP_EMPTY;
         end else if (top_ff >= TOP_EMPTY) begin
            rsp_next.valid  = 1'b1;
            rsp_next.status = vrs_pkg::ST_EMPTY;
            rsp_next.last   = 1'b1;
            rsp_next.empty  = 1'b1;
         end else begin
            mem_req.re    = 1'b1;
            mem_req.raddr = top_ff;
            state_in      = vrs_pkg::S_RDLEN;
         end
      end

      case (state_ff)
         vrs_pkg::S_PUSH1: begin
            // Write the first data byte
            mem_req.we    = 1'b1;
            mem_req.waddr = top_ff + HDR_T;
            mem_req.wdata = first_ff;
            state_in      = vrs_pkg::S_IDLE;
            if (ended_ff) begin
               if (bi_ff < rec_len_ff) begin
                  op_pend_in = 1'b0;
                  state_in   = vrs_pkg::S_FILL;
               end else begin
                  in_rec_in = 1'b0;
                  bi_in     = '0;
               end
            end
         end
         vrs_pkg::S_FILL: begin
            // Zero the missing bytes of a short record
            mem_req.we    = 1'b1;
            mem_req.waddr = top_ff + HDR_T + TW'(bi_ff);
            mem_req.wdata = '0;
            bi_in         = bi_inc;
            if (bi_inc >= rec_len_ff) begin
               in_rec_in = 1'b0;
               rej_in    = 1'b0;
               bi_in     = '0;
               state_in  = op_pend_ff ? vrs_pkg::S_OP : vrs_pkg::S_IDLE;
            end
         end
         vrs_pkg::S_RDLEN: begin
            // Header is in; free on pop, then start the read-out
            if (op_kind_ff == vrs_pkg::KIND_POP) begin
               top_in = (pop_top > (TW+1)'(TOP_EMPTY)) ? TOP_EMPTY : pop_top[TW-1:0];
            end
            if (n_copy == '0) begin
               rsp_next.valid  = 1'b1;
               rsp_next.status = vrs_pkg::ST_NO_COPY;
               rsp_next.last   = 1'b1;
               rsp_next.empty  = (top_in >= TOP_EMPTY);
               state_in        = vrs_pkg::S_IDLE;
            end else begin
               mem_req.re    = 1'b1;
               mem_req.raddr = top_ff + HDR_T;
               rd_ptr_in     = top_ff + HDR_T + TW'(1);
               cnt_in        = n_copy;
               state_in      = vrs_pkg::S_READ;
            end
         end
         vrs_pkg::S_READ: begin
            // Emit one byte, fetch the next
            rsp_next.valid  = 1'b1;
            rsp_next.status = vrs_pkg::ST_DATA;
            rsp_next.data   = mem_rdata;
            rsp_next.last   = (cnt_ff == LW'(1));
            rsp_next.empty  = (top_ff >= TOP_EMPTY);
            if (cnt_ff == LW'(1)) begin
               state_in = vrs_pkg::S_IDLE;
            end else begin
               mem_req.re    = 1'b1;
               mem_req.raddr = rd_ptr_ff;
               rd_ptr_in     = rd_ptr_ff + TW'(1);
               cnt_in        = cnt_ff - LW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= vrs_pkg::S_IDLE;
         top_ff     <= TOP_EMPTY;
         bi_ff      <= '0;
         in_rec_ff  <= 1'b0;
         rej_ff     <= 1'b0;
         op_pend_ff <= 1'b0;
         ended_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         top_ff     <= top_in;
         bi_ff      <= bi_in;
         in_rec_ff  <= in_rec_in;
         rej_ff     <= rej_in;
         op_pend_ff <= op_pend_in;
         ended_ff   <= ended_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rec_len_ff <= rec_len_in;
      op_kind_ff <= op_kind_in;
      op_len_ff  <= op_len_in;
      first_ff   <= first_in;
      rd_ptr_ff  <= rd_ptr_in;
      cnt_ff     <= cnt_in;
   end

endmodule

// File: rtl/core/variable_record_stack_core.sv
// Top level of the variable-length record stack: controller, byte store, result register.
// Depends on vrs_pkg, vrs_ram and vrs_ctrl.
//
//   channel   handshake               fields
//   request   start, busy             req_kind, req_data_byte, req_length, req_last_byte
//   response  rsp_strobe (one cycle)  rsp_status, rsp_data_byte_res, rsp_last, rsp_empty_res
//
// For an accepted record of nonzero length, the first data byte is written in S_PUSH1
// after the header (header and data share the single write port). A record closed short
// is zero filled byte by byte in S_FILL, and a pop, peek or clear that closes it then
// runs in S_OP. Pop and peek read the header in S_RDLEN and return the bytes in S_READ,
// or ST_EMPTY on an empty stack. Results appear in the cycle after they are produced.
// Reset is synchronous and empties the stack; the receiver cannot stall.
module variable_record_stack_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_kind,
   input  logic [vrs_pkg::DATA_W-1:0] req_data_byte,
   input  logic [vrs_pkg::LEN_W-1:0]  req_length,
   input  logic                       req_last_byte,
   output logic                       rsp_strobe,
   output logic [2:0]                 rsp_status,
   output logic [vrs_pkg::DATA_W-1:0] rsp_data_byte_res,
   output logic                       rsp_last,
   output logic                       rsp_empty_res
);

   vrs_pkg::mem_req_type       mem_req;
   logic [vrs_pkg::DATA_W-1:0] mem_rdata;
   vrs_pkg::rsp_type           rsp_in;
   vrs_pkg::rsp_type           rsp_ff;

   vrs_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_kind      (req_kind),
      .req_data_byte (req_data_byte),
      .req_length    (req_length),
      .req_last_byte (req_last_byte),
      .mem_req       (mem_req),
      .mem_rdata     (mem_rdata),
      .rsp_next      (rsp_in)
   );

   vrs_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (mem_rdata)
   );

   // Hold each result item for one cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff.valid <= 1'b0;
      end else begin
         rsp_ff.valid <= rsp_in.valid;
      end
      rsp_ff.status <= rsp_in.status;
      rsp_ff.data   <= rsp_in.data;
      rsp_ff.last   <= rsp_in.last;
      rsp_ff.empty  <= rsp_in.empty;
   end

   assign rsp_strobe        = rsp_ff.valid;
   assign rsp_status        = rsp_ff.status;
   assign rsp_data_byte_res = rsp_ff.data;
   assign rsp_last          = rsp_ff.last;
   assign rsp_empty_res     = rsp_ff.empty;

endmodule
